// File: rtl/fmmpx_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the
// FM stereo multiplex encoder. No dependencies.
`default_nettype none

package fmmpx_pkg;

    // sample and phase geometry
    localparam int SAMPLE_WIDTH     = 16;
    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER_LEN      = SINE_TABLE_DEPTH / 4;
    localparam int QADDR_BITS       = IDX_BITS - 1;

    // datapath widths
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int A_W    = SAMPLE_WIDTH + 17;
    localparam int B_W    = (DIFF_W > 17) ? DIFF_W : 17;
    localparam int P_W    = A_W + B_W;
    localparam int ACC_W  = P_W + 2;
    localparam int Q_W    = ACC_W - 32;
    localparam int CMP_W  = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1;

    // configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_GAIN    = 3'd4;

    // register reset values
    localparam logic [14:0]           RST_CLIP_THRESHOLD = 15'd17203;
    localparam logic [PHASE_BITS-1:0] RST_PILOT_STEP     = PHASE_BITS'(32'd425022780);
    localparam logic [15:0]           RST_MONO_GAIN      = 16'd29491;
    localparam logic [15:0]           RST_PILOT_GAIN     = 16'd5898;
    localparam logic [15:0]           RST_STEREO_GAIN    = 16'd29491;

    // sine generation constants (unsigned Q30)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // quarter-wave magnitude table, entries 0..QUARTER_LEN inclusive
    typedef logic [14:0] t_qrom [0:QUARTER_LEN];

    // Taylor series of sin in Q30 with truncating steps, rounded to Q15
    function automatic t_qrom build_qrom();
        t_qrom       tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] r;
        for (int j = 0; j <= QUARTER_LEN; j++) begin
            x  = (64'(j) * HALF_PI_Q30) / QUARTER_LEN;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            d  = ((x2 * t) >> 30) / 110;
            t  = (d >= ONE_Q30) ? 64'd0 : (ONE_Q30 - d);
            d  = ((x2 * t) >> 30) / 72;
            t  = (d >= ONE_Q30) ? 64'd0 : (ONE_Q30 - d);
            d  = ((x2 * t) >> 30) / 42;
            t  = (d >= ONE_Q30) ? 64'd0 : (ONE_Q30 - d);
            d  = ((x2 * t) >> 30) / 20;
            t  = (d >= ONE_Q30) ? 64'd0 : (ONE_Q30 - d);
            d  = ((x2 * t) >> 30) / 6;
            t  = (d >= ONE_Q30) ? 64'd0 : (ONE_Q30 - d);
            s  = (x * t) >> 30;
            r  = (s + 64'd16384) >> 15;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            tab[j] = r[14:0];
        end
        return tab;
    endfunction

    // microcode fields
    typedef enum logic [1:0] {
        A_SINE = 2'd0,
        A_PROD = 2'd1,
        A_SUM  = 2'd2
    } t_asel;

    typedef enum logic [1:0] {
        B_PGAIN  = 2'd0,
        B_DIFF   = 2'd1,
        B_STEREO = 2'd2,
        B_MONO   = 2'd3
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_HOLD  = 2'd0,
        ACC_PILOT = 2'd1,
        ACC_ADD   = 2'd2,
        ACC_MONO  = 2'd3
    } t_accop;

    typedef enum logic [1:0] {
        C_NONE = 2'd0,
        C_IN   = 2'd1,
        C_OUT  = 2'd2
    } t_cond;

    localparam int STEP_BITS = 3;
    localparam int UCODE_LEN = 2 ** STEP_BITS;

    typedef struct packed {
        t_asel                a_sel;
        t_bsel                b_sel;
        logic                 mul_en;
        t_accop               acc_op;
        logic                 rom_carrier;
        logic                 phase_adv;
        t_cond                cond;
        logic                 jump;
        logic [STEP_BITS-1:0] target;
    } t_uword;

    typedef t_uword t_uprog [0:UCODE_LEN-1];

    // program: capture, pilot term, carrier*diff, *stereo, mono term, emit
    localparam t_uprog UCODE = '{
        '{A_SINE, B_PGAIN,  1'b0, ACC_HOLD,  1'b0, 1'b0, C_IN,   1'b0, 3'd0},
        '{A_SINE, B_PGAIN,  1'b1, ACC_HOLD,  1'b1, 1'b0, C_NONE, 1'b0, 3'd0},
        '{A_SINE, B_DIFF,   1'b1, ACC_PILOT, 1'b0, 1'b1, C_NONE, 1'b0, 3'd0},
        '{A_PROD, B_STEREO, 1'b1, ACC_HOLD,  1'b0, 1'b0, C_NONE, 1'b0, 3'd0},
        '{A_SUM,  B_MONO,   1'b1, ACC_ADD,   1'b0, 1'b0, C_NONE, 1'b0, 3'd0},
        '{A_SINE, B_PGAIN,  1'b0, ACC_MONO,  1'b0, 1'b0, C_NONE, 1'b0, 3'd0},
        '{A_SINE, B_PGAIN,  1'b0, ACC_HOLD,  1'b0, 1'b0, C_OUT,  1'b1, 3'd0},
        '{A_SINE, B_PGAIN,  1'b0, ACC_HOLD,  1'b0, 1'b0, C_NONE, 1'b1, 3'd0}
    };

endpackage

`default_nettype wire

// File: rtl/fmmpx_ifs.sv
// Channel interfaces of the FM stereo multiplex encoder: sample pair in,
// multiplex sample out, configuration write. Depends on fmmpx_pkg.
`default_nettype none

interface fmmpx_smp_if import fmmpx_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_sample;
    logic signed [SAMPLE_WIDTH-1:0] right_sample;
    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface fmmpx_out_if import fmmpx_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] mpx_sample;
    modport source (output valid, mpx_sample, input ready);
    modport sink   (input valid, mpx_sample, output ready);
endinterface

interface fmmpx_cfg_if import fmmpx_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/fm_stereo_mpx_encoder_unit.sv
// Top level of the FM stereo multiplex encoder: microcoded sequencer over one
// shared multiplier, accumulator and sine ROM. Depends on fmmpx_pkg, fmmpx_ifs.
//
//   channel  | modport | word                        | accepted when
//   i_smp    | sink    | left_sample, right_sample   | valid && ready
//   o_mpx    | source  | mpx_sample                  | valid && ready
//   i_cfg    | sink    | index, data                 | valid && ready
//
// For each sample pair, a seven-step program in the microcode ROM drives the
// single multiplier through four products and the ROM through two reads.
// The output register frees the sequencer once the result is stored;
// the last step holds only while a previous result is still not taken.
// Reset is synchronous, active low: registers to defaults, phase to zero.
`default_nettype none

module fm_stereo_mpx_encoder_unit import fmmpx_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fmmpx_smp_if.sink   i_smp,
    fmmpx_out_if.source o_mpx,
    fmmpx_cfg_if.sink   i_cfg
);

    localparam t_qrom QROM = build_qrom();
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'sd1 <<< 31);
    localparam logic signed [Q_W-1:0] SMAX_Q = Q_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [Q_W-1:0] SMIN_Q = Q_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    // configuration registers
    logic [14:0]           r_clip_thr;
    logic [PHASE_BITS-1:0] r_phase_step;
    logic [15:0]           r_mono_gain;
    logic [15:0]           r_pilot_gain;
    logic [15:0]           r_stereo_gain;

    // sequencer and datapath state
    logic [STEP_BITS-1:0]        r_step;
    logic [PHASE_BITS-1:0]       r_phase;
    logic signed [DIFF_W-1:0]    r_sum;
    logic signed [DIFF_W-1:0]    r_diff;
    logic [14:0]                 r_sine_mag;
    logic                        r_sine_neg;
    logic signed [P_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic                        r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;

    t_uword                      uw;
    logic                        in_acc;
    logic                        out_busy;
    logic                        go;
    logic [STEP_BITS-1:0]        n_step;
    logic [IDX_BITS-1:0]         sine_idx;
    logic [QADDR_BITS-1:0]       fold_raw;
    logic [QADDR_BITS-1:0]       rom_addr;
    logic signed [15:0]          sine_val;
    logic signed [SAMPLE_WIDTH-1:0] clip_l;
    logic signed [SAMPLE_WIDTH-1:0] clip_r;
    logic signed [A_W-1:0]       op_a;
    logic signed [B_W-1:0]       op_b;
    logic signed [P_W-1:0]       mul_out;
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-1:0]     rounded;
    logic signed [Q_W-1:0]       q_val;
    logic signed [SAMPLE_WIDTH-1:0] sat_val;

    // symmetric hard clip against the threshold
    function automatic logic signed [SAMPLE_WIDTH-1:0] clip_sample(
        input logic signed [SAMPLE_WIDTH-1:0] x,
        input logic [14:0]                    thr
    );
        logic signed [CMP_W-1:0] xe;
        logic signed [CMP_W-1:0] te;
        logic signed [CMP_W-1:0] r;
        xe = CMP_W'(x);
        te = $signed({{(CMP_W-15){1'b0}}, thr});
        if (xe > te) begin
            r = te;
        end else if (xe < -te) begin
            r = -te;
        end else begin
            r = xe;
        end
        return SAMPLE_WIDTH'(r);
    endfunction

    assign uw       = UCODE[r_step];
    assign out_busy = r_out_valid && !o_mpx.ready;
    assign in_acc   = i_smp.valid && i_smp.ready;

    // handshakes
    assign i_smp.ready = i_rst_n && (uw.cond == C_IN);
    assign i_cfg.ready = i_rst_n;
    assign o_mpx.valid = r_out_valid;
    assign o_mpx.mpx_sample = r_out_sample;

    // step proceeds unless waiting on input or on a full output register
    assign go = !((uw.cond == C_IN) && !in_acc) && !((uw.cond == C_OUT) && out_busy);

    always_comb begin
        if (!go) begin
            n_step = r_step;
        end else if (uw.jump) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    // sine index for pilot or carrier (twice the phase), folded to a quarter
    assign sine_idx = uw.rom_carrier ? r_phase[PHASE_BITS-2 -: IDX_BITS]
                                     : r_phase[PHASE_BITS-1 -: IDX_BITS];
    assign fold_raw = sine_idx[QADDR_BITS-1:0];
    // second quarter mirrors: half length minus offset, modulo the address width
    assign rom_addr = (fold_raw > QADDR_BITS'(QUARTER_LEN)) ? (~fold_raw + 1'b1) : fold_raw;

    assign sine_val = r_sine_neg ? -$signed({1'b0, r_sine_mag}) : $signed({1'b0, r_sine_mag});

    // sine ROM, registered read
    always_ff @(posedge i_clk) begin
        r_sine_mag <= QROM[rom_addr];
        r_sine_neg <= sine_idx[IDX_BITS-1];
    end

    assign clip_l = clip_sample(i_smp.left_sample, r_clip_thr);
    assign clip_r = clip_sample(i_smp.right_sample, r_clip_thr);

    // shared multiplier operand selection
    always_comb begin
        case (uw.a_sel)
            A_SINE:  op_a = A_W'(sine_val);
            A_PROD:  op_a = A_W'(r_prod);
            A_SUM:   op_a = A_W'(r_sum);
            default: op_a = '0;
        endcase
        unique case (uw.b_sel)
            B_PGAIN:  op_b = B_W'($signed({1'b0, r_pilot_gain}));
            B_DIFF:   op_b = B_W'(r_diff);
            B_STEREO: op_b = B_W'($signed({1'b0, r_stereo_gain}));
            B_MONO:   op_b = B_W'($signed({1'b0, r_mono_gain}));
        endcase
    end

    // operands sign-extended to the product width
    assign mul_out  = P_W'(op_a) * P_W'(op_b);
    assign prod_ext = ACC_W'(r_prod);

    // round half up at 2^-32, then saturate
    assign rounded = r_acc + RND;
    assign q_val   = Q_W'(rounded >>> 32);

    always_comb begin
        if (q_val > SMAX_Q) begin
            sat_val = SAMPLE_WIDTH'(SMAX_Q);
        end else if (q_val < SMIN_Q) begin
            sat_val = SAMPLE_WIDTH'(SMIN_Q);
        end else begin
            sat_val = SAMPLE_WIDTH'(q_val);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((uw.cond == C_IN) && in_acc) begin
            r_sum  <= DIFF_W'(clip_l) + DIFF_W'(clip_r);
            r_diff <= DIFF_W'(clip_l) - DIFF_W'(clip_r);
        end
        if (go && uw.mul_en) begin
            r_prod <= mul_out;
        end
        if (go) begin
            unique case (uw.acc_op)
                ACC_HOLD:  r_acc <= r_acc;
                ACC_PILOT: r_acc <= prod_ext <<< SAMPLE_WIDTH;
                ACC_ADD:   r_acc <= r_acc + prod_ext;
                ACC_MONO:  r_acc <= r_acc + (prod_ext <<< 15);
            endcase
        end
        if (go && (uw.cond == C_OUT)) begin
            r_out_sample <= sat_val;
        end
    end

    // control registers: step, phase, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (go && uw.phase_adv) begin
                r_phase <= r_phase + r_phase_step;
            end
            if (go && (uw.cond == C_OUT)) begin
                r_out_valid <= 1'b1;
            end else if (o_mpx.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_thr    <= RST_CLIP_THRESHOLD;
            r_phase_step  <= RST_PILOT_STEP;
            r_mono_gain   <= RST_MONO_GAIN;
            r_pilot_gain  <= RST_PILOT_GAIN;
            r_stereo_gain <= RST_STEREO_GAIN;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_CLIP_THRESHOLD: r_clip_thr    <= i_cfg.data[14:0];
                CFG_PILOT_STEP:     r_phase_step  <= i_cfg.data[PHASE_BITS-1:0];
                CFG_MONO_GAIN:      r_mono_gain   <= i_cfg.data[15:0];
                CFG_PILOT_GAIN:     r_pilot_gain  <= i_cfg.data[15:0];
                CFG_STEREO_GAIN:    r_stereo_gain <= i_cfg.data[15:0];
                default:            ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/fmmpx_checker.sv
// Port-level assertions for the FM stereo multiplex encoder and the bind that
// attaches them to the top level. Depends on fmmpx_pkg.
`default_nettype none

module fmmpx_checker import fmmpx_pkg::*; (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_valid,
    input wire                           i_in_ready,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire [SAMPLE_WIDTH-1:0]        i_out_sample,
    input wire                           i_cfg_ready
);

    // a stalled result word stays and holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample))
        else $error("result word dropped or changed under stall");

    // the sequencer is busy for the cycles after a sample pair is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("new sample pair taken while the program still runs");

    // a new result appears exactly as the program returns to its first step
    a_emit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("sequencer did not return to capture after emitting");

    // configuration is always writable out of reset
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind fm_stereo_mpx_encoder_unit fmmpx_checker u_fmmpx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_out_valid  (o_mpx.valid),
    .i_out_ready  (o_mpx.ready),
    .i_out_sample (o_mpx.mpx_sample),
    .i_cfg_ready  (i_cfg.ready)
);

`default_nettype wire
